FILE: hdl/stt_pkg.sv
// ============================================================================
// stt_pkg
// Shared codes and types for the software timer table.
// ============================================================================
package stt_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_STOP = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ARG  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

endpackage

FILE: hdl/stt_ram.sv
// ============================================================================
// stt_ram
// Simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module stt_ram #(
    parameter int DEPTH = 10,
    parameter int WIDTH = 73
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: hdl/software_timer_table.sv
// ============================================================================
// software_timer_table
// Ordered table of software timers with add, stop and tick commands.
// ============================================================================
// The timers live in one RAM, in the order in which they were added. Every
// command that touches the table streams it once: the entry at the read index
// comes out of the registered RAM read port in the cycle after its address, is
// checked, and is written back at a separate write index that lags behind
// whenever an entry is removed. That compacts the table in the same pass, so
// an entry that moves up is still checked by the same tick. The scan is paced
// by the single RAM read port, and a full output register can stall it. A new
// command is taken only when idle, after the last one is through. An add that
// is rejected, a stop with id zero and any command on an empty table skip the
// scan. An add for a new id appends at the end in the final cycle. Expiry
// reports are held back by one so that the final beat of a tick carries the
// last flag; a tick with no expiry produces no beat. Opcode three is dropped.
module software_timer_table #(
    parameter int MAX_SLOTS  = 10,
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_timer_id,
    input  logic [31:0] i_timeout,
    input  logic        i_repeat_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_expired_id,
    output logic        o_last
);

    import stt_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int EW = 8 + 2 * COUNT_BITS + 1;
    localparam int LW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    t_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_tick;
    logic [CW-1:0]         r_used;
    t_opcode               r_op;
    logic [7:0]            r_id;
    logic [COUNT_BITS-1:0] r_lim;
    logic                  r_rep;
    t_status               r_err;
    logic                  r_found;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         r_wr;
    logic                  r_pendv;
    logic [7:0]            r_pid;

    logic       r_ovalid;
    logic       r_okind;
    t_status    r_ostat;
    logic [7:0] r_oid;
    logic       r_olast;

    // RAM port signals
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    stt_ram #(.DEPTH(MAX_SLOTS), .WIDTH(EW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Entry layout: id, limit, start tick, periodic flag.
    logic [7:0]            e_id;
    logic [COUNT_BITS-1:0] e_lim, e_start, elapsed;
    logic                  e_per;
    assign e_id    = ram_rdata[EW-1 -: 8];
    assign e_lim   = ram_rdata[2*COUNT_BITS : COUNT_BITS+1];
    assign e_start = ram_rdata[COUNT_BITS:1];
    assign e_per   = ram_rdata[0];
    assign elapsed = r_tick - e_start;

    // Incoming command decode.
    logic [LW-1:0] lim_ext;
    logic          too_wide, accept;
    t_opcode       in_op;
    assign lim_ext  = LW'(i_timeout);
    assign too_wide = (lim_ext >> COUNT_BITS) != '0;
    assign in_op    = t_opcode'(i_opcode);
    assign accept   = i_in_valid && o_in_ready;

    logic          expired, match, out_free, scan_stall, has_next, done_go, out_load;
    logic [CW-1:0] idx_nx;
    assign expired    = elapsed > e_lim;
    assign match      = (e_id == r_id) && !r_found;
    assign out_free   = !r_ovalid || i_out_ready;
    assign scan_stall = (r_op == OP_TICK) && expired && r_pendv && !out_free;
    assign idx_nx     = CW'(r_idx) + CW'(1);
    assign has_next   = idx_nx < r_used;
    assign done_go    = out_free || ((r_op == OP_TICK) && !r_pendv);

    // The output register takes a new beat when a held expiry report is
    // handed on mid-scan, or when a command finishes with a beat to send.
    assign out_load = ((r_state == S_SCAN) && !scan_stall && (r_op == OP_TICK) &&
                       expired && r_pendv) ||
                      ((r_state == S_DONE) && done_go &&
                       ((r_op != OP_TICK) || r_pendv));

    assign o_in_ready = (r_state == S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (in_op == OP_NONE)                    n_state = S_IDLE;
                    else if (in_op == OP_ADD &&
                             (too_wide || r_used >= CW'(MAX_SLOTS)))  n_state = S_DONE;
                    else if (in_op == OP_STOP && i_timer_id == 8'd0)  n_state = S_DONE;
                    else if (r_used == '0)                            n_state = S_DONE;
                    else                                              n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!scan_stall && !has_next) n_state = S_DONE;
            end
            S_DONE: begin
                if (done_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM control: reads stream ahead, writes compact behind.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = r_wr[AW-1:0];
        ram_wdata = ram_rdata;
        unique case (r_state)
            S_IDLE: begin
                ram_re = accept;
            end
            S_SCAN: begin
                if (!scan_stall) begin
                    ram_re    = has_next;
                    ram_raddr = idx_nx[AW-1:0];
                    unique case (r_op)
                        OP_TICK: begin
                            ram_we    = !(expired && !e_per);
                            ram_wdata = {e_id, e_lim, expired ? r_tick : e_start, e_per};
                        end
                        OP_ADD: begin
                            ram_we    = 1'b1;
                            ram_wdata = match ? {r_id, r_lim, r_tick, r_rep} : ram_rdata;
                        end
                        OP_STOP: ram_we = !match;
                        default: ram_we = 1'b0;
                    endcase
                end
            end
            S_DONE: begin
                ram_waddr = r_used[AW-1:0];
                ram_wdata = {r_id, r_lim, r_tick, r_rep};
                ram_we    = done_go && (r_op == OP_ADD) && !r_found && (r_err == ST_OK);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tick   <= '0;
            r_used   <= '0;
            r_pendv  <= 1'b0;
            r_ovalid <= 1'b0;
            r_op     <= OP_NONE;
            r_found  <= 1'b0;
            r_idx    <= '0;
            r_wr     <= '0;
            r_err    <= ST_OK;
        end else begin
            r_state <= n_state;
            if (out_load) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= in_op;
                        r_id    <= i_timer_id;
                        r_lim   <= lim_ext[COUNT_BITS-1:0];
                        r_rep   <= i_repeat_req;
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        r_wr    <= '0;
                        r_pendv <= 1'b0;
                        priority if (in_op == OP_ADD && too_wide)          r_err <= ST_ARG;
                        else if (in_op == OP_ADD && r_used >= CW'(MAX_SLOTS)) r_err <= ST_FULL;
                        else if (in_op == OP_STOP && i_timer_id == 8'd0)   r_err <= ST_ARG;
                        else                                               r_err <= ST_OK;
                    end
                end
                S_SCAN: begin
                    if (!scan_stall) begin
                        if (ram_we) r_wr <= r_wr + CW'(1);
                        if (match && (r_op == OP_ADD || r_op == OP_STOP)) r_found <= 1'b1;
                        r_idx <= idx_nx[AW-1:0];
                        if (r_op == OP_TICK && expired) begin
                            // Hand the previous report on, keep this one back.
                            if (r_pendv) begin
                                r_okind  <= KIND_EXPIRY;
                                r_ostat  <= ST_OK;
                                r_oid    <= r_pid;
                                r_olast  <= 1'b0;
                            end
                            r_pendv <= 1'b1;
                            r_pid   <= e_id;
                        end
                    end
                end
                S_DONE: begin
                    if (done_go) begin
                        unique case (r_op)
                            OP_TICK: begin
                                r_tick <= r_tick + COUNT_BITS'(1);
                                r_used <= r_wr;
                                if (r_pendv) begin
                                    r_okind  <= KIND_EXPIRY;
                                    r_ostat  <= ST_OK;
                                    r_oid    <= r_pid;
                                    r_olast  <= 1'b1;
                                end
                                r_pendv <= 1'b0;
                            end
                            OP_ADD: begin
                                if (!r_found && r_err == ST_OK) r_used <= r_used + CW'(1);
                                r_okind  <= KIND_STATUS;
                                r_ostat  <= r_err;
                                r_oid    <= 8'd0;
                                r_olast  <= 1'b1;
                            end
                            OP_STOP: begin
                                if (r_found) r_used <= r_used - CW'(1);
                                r_okind  <= KIND_STATUS;
                                r_ostat  <= r_found ? ST_OK : ST_ARG;
                                r_oid    <= 8'd0;
                                r_olast  <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_kind       = r_okind;
    assign o_status     = r_ostat;
    assign o_expired_id = r_oid;
    assign o_last       = r_olast;

endmodule

FILE: tb/software_timer_table_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// software_timer_table_tb
// Self-checking testbench for the ordered software timer table.
// ============================================================================
// A predictor keeps its own copy of the timer table. For every accepted
// command beat it works out the expected result beats and queues them. A
// checker process compares every accepted result beat, field by field, with
// the oldest queued beat. The sender works in bursts with gaps, and the
// receiver stalls on its own pattern.
module software_timer_table_tb;
    import stt_pkg::*;

    localparam int SLOTS      = 10;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [7:0] expired_id;
        logic       last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = OP_TICK;
    logic [7:0]  i_timer_id = 8'd0;
    logic [31:0] i_timeout = 32'd0;
    logic        i_repeat_req = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_kind;
    logic [1:0]  o_status;
    logic [7:0]  o_expired_id;
    logic        o_last;

    // Predictor state.
    logic [31:0] tick_now;
    int          used;
    logic [7:0]  tab_id    [SLOTS];
    logic [31:0] tab_limit [SLOTS];
    logic [31:0] tab_start [SLOTS];
    logic        tab_rep   [SLOTS];

    t_beat pending_beats[$];
    int    errors = 0;
    int    beats_seen = 0;
    int    expiries_seen = 0;
    int    cmds_sent = 0;
    int    idle_cycles = 0;
    int    stall_mode = 0;

    software_timer_table dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Removes one entry and moves the later entries up by one place.
    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < used; i++) begin
            tab_id[i]    = tab_id[i + 1];
            tab_limit[i] = tab_limit[i + 1];
            tab_start[i] = tab_start[i + 1];
            tab_rep[i]   = tab_rep[i + 1];
        end
        used--;
    endfunction

    function automatic t_beat status_beat(input t_status st);
        t_beat b;
        b.kind = KIND_STATUS;
        b.status = st;
        b.expired_id = 8'd0;
        b.last = 1'b1;
        return b;
    endfunction

    // Applies one command to the table copy and queues its result beats.
    function automatic void predict_timers(input logic [1:0] op, input logic [7:0] id,
                                           input logic [31:0] lim, input logic rep);
        t_beat   b;
        t_status st;
        bit      found;
        int      i;
        int      n;
        case (op)
            OP_ADD: begin
                st = ST_OK;
                found = 0;
                if (used >= SLOTS) begin
                    st = ST_FULL;
                end else begin
                    for (i = 0; i < used; i++) begin
                        if (!found && tab_id[i] == id) begin
                            found = 1;
                            tab_start[i] = tick_now;
                            tab_limit[i] = lim;
                            tab_rep[i] = rep;
                        end
                    end
                    if (!found) begin
                        tab_id[used] = id;
                        tab_limit[used] = lim;
                        tab_start[used] = tick_now;
                        tab_rep[used] = rep;
                        used++;
                    end
                end
                pending_beats.push_back(status_beat(st));
            end
            OP_STOP: begin
                st = ST_ARG;
                if (id != 8'd0) begin
                    for (i = 0; i < used; i++) begin
                        if (tab_id[i] == id) begin
                            drop_entry(i);
                            st = ST_OK;
                            break;
                        end
                    end
                end
                pending_beats.push_back(status_beat(st));
            end
            OP_TICK: begin
                i = 0;
                n = 0;
                while (i < used) begin
                    if (tick_now - tab_start[i] > tab_limit[i]) begin
                        b.kind = KIND_EXPIRY;
                        b.status = ST_OK;
                        b.expired_id = tab_id[i];
                        b.last = 1'b0;
                        pending_beats.push_back(b);
                        n++;
                        if (tab_rep[i]) begin
                            tab_start[i] = tick_now;
                            i++;
                        end else begin
                            drop_entry(i);
                        end
                    end else begin
                        i++;
                    end
                end
                // Only the final expiry beat of a tick carries the last flag.
                if (n > 0) pending_beats[$].last = 1'b1;
                tick_now = tick_now + 32'd1;
            end
            default: ;
        endcase
    endfunction

    // Sends one command beat; the prediction is made at acceptance. Valid is
    // left high on return, at a falling edge, so that the next command or a
    // gap takes over the input in that same step.
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] id,
                            input logic [31:0] lim, input logic rep);
        i_opcode <= op;
        i_timer_id <= id;
        i_timeout <= lim;
        i_repeat_req <= rep;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_timers(op, id, lim, rep);
        cmds_sent++;
        @(negedge i_clk);
    endtask

    // Random gap between bursts; zero inside a burst.
    task automatic sender_gap(input int burst_left);
        int gap;
        gap = (burst_left > 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) i_in_valid <= 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // Receiver stall pattern: phases of always ready, toggling, and sparse.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ~i_out_ready;
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            if (o_kind == KIND_EXPIRY) expiries_seen++;
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0b id %0d",
                                          o_kind, o_expired_id));
            end else begin
                want = pending_beats.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch($sformatf("kind %0b want %0b", o_kind, want.kind));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", o_status, want.status));
                if (o_expired_id !== want.expired_id)
                    report_mismatch($sformatf("id %0d want %0d", o_expired_id,
                                              want.expired_id));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b want %0b", o_last, want.last));
            end
        end
    end

    // Watchdog on cycles in which no beat is accepted on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Directed: extremes, every opcode and each special case.
    task automatic test_directed();
        send_cmd(OP_STOP, 8'd5, 32'd0, 1'b0);         // stop on empty table
        send_cmd(OP_STOP, 8'd0, 32'd0, 1'b0);         // stop with id zero
        send_cmd(OP_TICK, 8'd0, 32'd0, 1'b0);         // tick, nothing there
        send_cmd(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 1'b1); // dropped opcode
        send_cmd(OP_ADD, 8'd0, 32'd0, 1'b0);          // id zero is accepted
        send_cmd(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(OP_ADD, 8'd7, 32'd0, 1'b1);
        send_cmd(OP_ADD, 8'd8, 32'd1, 1'b0);
        send_cmd(OP_ADD, 8'd7, 32'd0, 1'b0);          // refresh as one-shot
        send_cmd(OP_TICK, 8'd0, 32'd0, 1'b0);
        send_cmd(OP_TICK, 8'd0, 32'd0, 1'b0);
        send_cmd(OP_TICK, 8'd0, 32'd0, 1'b0);
        for (int k = 1; k <= 10; k++)
            send_cmd(OP_ADD, 8'(k + 20), 32'd0, k[0]);
        send_cmd(OP_ADD, 8'hFF, 32'd3, 1'b0);         // full, even for a known id
        // Periodic and one-shot entries expire together, so entries move up mid-scan.
        send_cmd(OP_TICK, 8'd0, 32'd0, 1'b0);
        send_cmd(OP_TICK, 8'd0, 32'd0, 1'b0);
        send_cmd(OP_STOP, 8'd22, 32'd0, 1'b0);
        wait_drained();
    endtask

    // Random: mostly well-formed add/tick/stop traffic on a small id pool.
    task automatic test_random(input int count);
        logic [1:0]  op;
        logic [7:0]  id;
        logic [31:0] lim;
        int          burst;
        int          r;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) op = OP_TICK;
            else if (r < 75) op = OP_ADD;
            else if (r < 96) op = OP_STOP;
            else op = OP_NONE;
            id = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 14));
            r = $urandom_range(0, 19);
            if (r == 0) lim = $urandom;
            else if (r == 1) lim = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            else lim = $urandom_range(0, 6);
            send_cmd(op, id, lim, 1'($urandom));
            if (burst > 0) burst--;
            else burst = $urandom_range(0, 12);
            sender_gap(burst);
        end
        wait_drained();
    endtask

    initial begin
        used = 0;
        tick_now = 32'd0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(310);
        $display("sent %0d commands, checked %0d result beats (%0d expiries)",
                 cmds_sent, beats_seen, expiries_seen);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d beats missing", errors, pending_beats.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hdl/stt_pkg.sv
hdl/stt_ram.sv
hdl/software_timer_table.sv
tb/software_timer_table_tb.sv
